[sv/hts_pkg.sv]
// Shared types, constants and tables of the haversine track distance block.
package hts_pkg;

    localparam int LAT_W      = 31;
    localparam int LON_W      = 32;
    localparam int DIST_W     = 48;
    localparam int RADIUS_W   = 23;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

    // CORDIC datapath width and Q30 constants
    localparam int CW = 34;
    localparam int Q30_W = 31;
    localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

    // digit-serial multiplier geometry
    localparam int MUL_AW     = 34;
    localparam int MUL_DW     = 4;
    localparam int MUL_DIGITS = 9;
    localparam int MUL_BW     = MUL_DW * MUL_DIGITS;
    localparam int MUL_PW     = 2 * MUL_AW;

    // square root unit geometry
    localparam int SQ_NW = 62;

    localparam logic [MUL_AW-1:0] HALF_SCALE = 34'd2012227627;
    localparam logic [33:0] U360_34 = 34'd3600000000;
    localparam logic [33:0] U180_34 = 34'd1800000000;
    localparam logic [30:0] U180_31 = 31'd1800000000;
    localparam logic [30:0] U90_31  = 31'd900000000;

    typedef struct packed {
        logic signed [LAT_W-1:0] latitude;
        logic signed [LON_W-1:0] longitude;
        logic                    last_point;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] total_distance_mm;
        logic              saturated;
    } t_out_item;

    typedef enum logic [0:0] {
        CM_ROTATE,
        CM_VECTOR
    } t_cordic_mode;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DLAT_HALF,
        S_DLAT_CORD,
        S_DLON_HALF,
        S_DLON_CORD,
        S_C1_HALF,
        S_C1_CORD,
        S_C2_HALF,
        S_C2_CORD,
        S_S1SQ,
        S_S2SQ,
        S_CC,
        S_A,
        S_SQY,
        S_SQX,
        S_ATAN,
        S_MM,
        S_FIN,
        S_OUT
    } t_state;

    function automatic logic signed [CW-1:0] atan_q30(input logic [5:0] i);
        logic signed [CW-1:0] v;
        case (i)
            6'd0: v = 34'sd843314857;
            6'd1: v = 34'sd497837829;
            6'd2: v = 34'sd263043837;
            6'd3: v = 34'sd133525159;
            6'd4: v = 34'sd67021687;
            6'd5: v = 34'sd33543516;
            6'd6: v = 34'sd16775851;
            6'd7: v = 34'sd8388437;
            6'd8: v = 34'sd4194283;
            6'd9: v = 34'sd2097149;
            default: begin
                if (i <= 6'd30) begin
                    v = 34'sd1 <<< (6'd30 - i);
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

[sv/hts_mult.sv]
// Digit-serial unsigned multiplier, one radix-16 digit of the multiplier per cycle.
module hts_mult (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hts_pkg::MUL_AW-1:0]    i_a,
    input  logic [hts_pkg::MUL_AW-1:0]    i_b,
    output logic                          o_done,
    output logic [hts_pkg::MUL_PW-1:0]    o_p
);
    localparam int AW = hts_pkg::MUL_AW;
    localparam int DW = hts_pkg::MUL_DW;
    localparam int BW = hts_pkg::MUL_BW;
    localparam int HW = AW + DW;
    localparam int KW = $clog2(hts_pkg::MUL_DIGITS);

    logic [AW-1:0]    r_a;
    logic [HW-1:0]    r_acc;
    logic [BW-1:0]    r_lo;
    logic [KW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [HW-1:0]    prod;
    logic [HW-1:0]    sum;
    logic [HW+BW-1:0] w;

    always_comb begin
        prod = {{DW{1'b0}}, r_a} * {{AW{1'b0}}, r_lo[DW-1:0]};
        sum  = r_acc + prod;
        w    = {sum, r_lo} >> DW;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == KW'(hts_pkg::MUL_DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= '0;
            r_lo  <= {{(BW-AW){1'b0}}, i_b};
        end else if (r_busy) begin
            r_acc <= w[HW+BW-1:BW];
            r_lo  <= w[BW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_p    = {r_acc[hts_pkg::MUL_PW-BW-1:0], r_lo};

endmodule

[sv/hts_cordic.sv]
// Iterative CORDIC, one micro-rotation per cycle, rotation and vectoring modes.
module hts_cordic #(
    parameter int CORDIC_STEPS = hts_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  hts_pkg::t_cordic_mode              i_mode,
    input  logic signed [hts_pkg::CW-1:0]      i_x,
    input  logic signed [hts_pkg::CW-1:0]      i_y,
    input  logic signed [hts_pkg::CW-1:0]      i_z,
    output logic                               o_done,
    output logic signed [hts_pkg::CW-1:0]      o_x,
    output logic signed [hts_pkg::CW-1:0]      o_y,
    output logic signed [hts_pkg::CW-1:0]      o_z
);
    localparam int CW = hts_pkg::CW;
    localparam int IW = $clog2(CORDIC_STEPS);

    hts_pkg::t_cordic_mode   r_mode;
    logic [IW-1:0]           r_i;
    logic                    r_busy;
    logic                    r_done;
    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic signed [CW-1:0]    r_z;
    logic [5:0]              sh;
    logic signed [CW-1:0]    dx;
    logic signed [CW-1:0]    dy;
    logic signed [CW-1:0]    at;
    logic                    pos;

    always_comb begin
        sh  = 6'(r_i);
        dx  = r_y >>> sh;
        dy  = r_x >>> sh;
        at  = hts_pkg::atan_q30(sh);
        pos = (r_mode == hts_pkg::CM_ROTATE) ? !r_z[CW-1] : r_y[CW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode <= i_mode;
            r_x    <= i_x;
            r_y    <= i_y;
            r_z    <= i_z;
        end else if (r_busy) begin
            if (pos) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

[sv/hts_isqrt.sv]
// Restoring bit-serial integer square root, one root bit per cycle.
module hts_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hts_pkg::SQ_NW-1:0]     i_n,
    output logic                          o_done,
    output logic [hts_pkg::Q30_W-1:0]     o_root
);
    localparam int NW = hts_pkg::SQ_NW;

    logic [NW-1:0] r_n;
    logic [NW-1:0] r_res;
    logic [NW-1:0] r_bit;
    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] t;

    assign t = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_res <= '0;
            r_bit <= NW'(1) << (NW - 2);
        end else if (r_busy) begin
            if (r_n >= t) begin
                r_n   <= r_n - t;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[hts_pkg::Q30_W-1:0];

endmodule

[sv/haversine_track_distance.sv]
// Top level: track point sequencer, shared multiplier, CORDIC and square root units.
// One item at a time; a point with a predecessor takes five CORDIC runs, nine multiplies,
// two square roots and the S_IDLE and S_FIN control states; a first point takes S_IDLE, S_FIN.
// A point marked last also passes S_OUT, which waits until the output register is free;
// its result then waits in the output register. Reset clears track, sets radius.
module haversine_track_distance #(
    parameter int CORDIC_STEPS = hts_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  hts_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output hts_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_we,
    input  logic [hts_pkg::RADIUS_W-1:0]      i_cfg_wdata
);
    localparam int CW = hts_pkg::CW;
    localparam int QW = hts_pkg::Q30_W;
    localparam int PW = hts_pkg::MUL_PW;
    localparam int DW = hts_pkg::DIST_W;
    localparam logic [PW-1:0] RND30 = PW'(1) << 29;
    localparam logic [PW-1:0] RND31 = PW'(1) << 30;
    localparam logic [PW-1:0] CEIL30 = (PW'(1) << 30) - PW'(1);

    function automatic logic [QW-1:0] fold_diff(input logic signed [33:0] d);
        logic [33:0] m;
        m = d[33] ? 34'(-d) : 34'(d);
        if (m >= hts_pkg::U360_34) begin
            m = m - hts_pkg::U360_34;
        end
        if (m > hts_pkg::U180_34) begin
            m = hts_pkg::U360_34 - m;
        end
        return m[QW-1:0];
    endfunction

    function automatic logic [QW-1:0] lat_mag(input logic signed [hts_pkg::LAT_W-1:0] lat);
        logic [QW-1:0] m;
        m = lat[hts_pkg::LAT_W-1] ? QW'(~lat + 31'd1) : QW'(lat);
        return m;
    endfunction

    function automatic logic [QW-1:0] lat_arg(input logic signed [hts_pkg::LAT_W-1:0] lat);
        logic [QW-1:0] m;
        logic [QW-1:0] u;
        m = lat_mag(lat);
        u = (m > hts_pkg::U90_31) ? hts_pkg::U180_31 - m : m;
        return {u[QW-2:0], 1'b0};
    endfunction

    function automatic logic [QW-1:0] clamp_q30(input logic signed [CW-1:0] v);
        logic [QW-1:0] r;
        if (v[CW-1]) begin
            r = '0;
        end else if (v > hts_pkg::ONE_Q30) begin
            r = QW'(hts_pkg::ONE_Q30);
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    hts_pkg::t_state    r_state, n_state;
    logic               r_issued, n_issued;
    logic [hts_pkg::RADIUS_W-1:0] r_radius, n_radius;
    logic signed [hts_pkg::LAT_W-1:0] r_lat, n_lat, r_plat, n_plat;
    logic signed [hts_pkg::LON_W-1:0] r_lon, n_lon, r_plon, n_plon;
    logic               r_last, n_last;
    logic               r_have_prev, n_have_prev;
    logic               r_ovf, n_ovf;
    logic [DW-1:0]      r_total, n_total;
    logic signed [CW-1:0] r_ang, n_ang;
    logic [QW-1:0]      r_s1, n_s1, r_s2, n_s2;
    logic [QW-1:0]      r_c1m, n_c1m, r_c2m, n_c2m;
    logic               r_c1n, n_c1n, r_c2n, n_c2n;
    logic [QW-1:0]      r_s1sq, n_s1sq, r_s2sq, n_s2sq;
    logic [QW-1:0]      r_ccm, n_ccm;
    logic               r_ccn, n_ccn;
    logic [QW-1:0]      r_a, n_a, r_sy, n_sy, r_sx, n_sx;
    logic [CW-1:0]      r_theta, n_theta;
    logic [34:0]        r_mm, n_mm;
    logic               r_out_valid, n_out_valid;
    hts_pkg::t_out_item r_out_item, n_out_item;

    logic               mul_start, mul_done;
    logic [hts_pkg::MUL_AW-1:0] mul_a, mul_b;
    logic [PW-1:0]      mul_p;
    logic               cor_start, cor_done;
    hts_pkg::t_cordic_mode cor_mode;
    logic signed [CW-1:0] cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;
    logic               sq_start, sq_done;
    logic [hts_pkg::SQ_NW-1:0] sq_n;
    logic [QW-1:0]      sq_root;

    logic               run_mul, run_cor, run_sq, step_done;
    logic signed [33:0] d_lat, d_lon;
    logic [hts_pkg::MUL_AW-1:0] r2000;
    logic [PW-1:0]      p_rnd30, p_rnd31, p_floor30, p_ceil30;
    logic [QW-1:0]      term;
    logic signed [CW-1:0] a_sum;
    logic [DW:0]        sum;

    always_comb begin
        d_lat = {{3{r_plat[hts_pkg::LAT_W-1]}}, r_plat} - {{3{r_lat[hts_pkg::LAT_W-1]}}, r_lat};
        d_lon = {{2{r_plon[hts_pkg::LON_W-1]}}, r_plon} - {{2{r_lon[hts_pkg::LON_W-1]}}, r_lon};
        r2000 = (34'(r_radius) << 11) - (34'(r_radius) << 5) - (34'(r_radius) << 4);
        p_rnd30   = (mul_p + RND30) >> 30;
        p_rnd31   = (mul_p + RND31) >> 31;
        p_floor30 = mul_p >> 30;
        p_ceil30  = (mul_p + CEIL30) >> 30;
        term  = r_ccn ? p_ceil30[QW-1:0] : p_floor30[QW-1:0];
        a_sum = r_ccn ? CW'(r_s1sq) - CW'(term) : CW'(r_s1sq) + CW'(term);
        sum   = {1'b0, r_total} + (DW+1)'(r_mm);
    end

    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        n_radius    = r_radius;
        n_lat       = r_lat;
        n_lon       = r_lon;
        n_last      = r_last;
        n_plat      = r_plat;
        n_plon      = r_plon;
        n_have_prev = r_have_prev;
        n_ovf       = r_ovf;
        n_total     = r_total;
        n_ang       = r_ang;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_c1m       = r_c1m;
        n_c2m       = r_c2m;
        n_c1n       = r_c1n;
        n_c2n       = r_c2n;
        n_s1sq      = r_s1sq;
        n_s2sq      = r_s2sq;
        n_ccm       = r_ccm;
        n_ccn       = r_ccn;
        n_a         = r_a;
        n_sy        = r_sy;
        n_sx        = r_sx;
        n_theta     = r_theta;
        n_mm        = r_mm;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        run_mul     = 1'b0;
        run_cor     = 1'b0;
        run_sq      = 1'b0;
        mul_a       = hts_pkg::HALF_SCALE;
        mul_b       = '0;
        cor_mode    = hts_pkg::CM_ROTATE;
        cor_x0      = hts_pkg::INV_GAIN;
        cor_y0      = '0;
        cor_z0      = r_ang;
        sq_n        = hts_pkg::SQ_NW'(r_a) << 30;
        step_done   = mul_done | cor_done | sq_done;

        if (i_cfg_we) begin
            n_radius = i_cfg_wdata;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            hts_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_lat   = i_in_item.latitude;
                    n_lon   = i_in_item.longitude;
                    n_last  = i_in_item.last_point;
                    n_mm    = '0;
                    n_state = r_have_prev ? hts_pkg::S_DLAT_HALF : hts_pkg::S_FIN;
                end
            end
            hts_pkg::S_DLAT_HALF: begin
                run_mul = 1'b1;
                mul_b   = 34'(fold_diff(d_lat));
                if (mul_done) begin
                    n_ang   = p_rnd31[CW-1:0];
                    n_state = hts_pkg::S_DLAT_CORD;
                end
            end
            hts_pkg::S_DLAT_CORD: begin
                run_cor = 1'b1;
                if (cor_done) begin
                    n_s1    = clamp_q30(cor_y);
                    n_state = hts_pkg::S_DLON_HALF;
                end
            end
            hts_pkg::S_DLON_HALF: begin
                run_mul = 1'b1;
                mul_b   = 34'(fold_diff(d_lon));
                if (mul_done) begin
                    n_ang   = p_rnd31[CW-1:0];
                    n_state = hts_pkg::S_DLON_CORD;
                end
            end
            hts_pkg::S_DLON_CORD: begin
                run_cor = 1'b1;
                if (cor_done) begin
                    n_s2    = clamp_q30(cor_y);
                    n_state = hts_pkg::S_C1_HALF;
                end
            end
            hts_pkg::S_C1_HALF: begin
                run_mul = 1'b1;
                mul_b   = 34'(lat_arg(r_plat));
                if (mul_done) begin
                    n_ang   = p_rnd31[CW-1:0];
                    n_state = hts_pkg::S_C1_CORD;
                end
            end
            hts_pkg::S_C1_CORD: begin
                run_cor = 1'b1;
                if (cor_done) begin
                    n_c1m   = clamp_q30(cor_x);
                    n_c1n   = lat_mag(r_plat) > hts_pkg::U90_31;
                    n_state = hts_pkg::S_C2_HALF;
                end
            end
            hts_pkg::S_C2_HALF: begin
                run_mul = 1'b1;
                mul_b   = 34'(lat_arg(r_lat));
                if (mul_done) begin
                    n_ang   = p_rnd31[CW-1:0];
                    n_state = hts_pkg::S_C2_CORD;
                end
            end
            hts_pkg::S_C2_CORD: begin
                run_cor = 1'b1;
                if (cor_done) begin
                    n_c2m   = clamp_q30(cor_x);
                    n_c2n   = lat_mag(r_lat) > hts_pkg::U90_31;
                    n_state = hts_pkg::S_S1SQ;
                end
            end
            hts_pkg::S_S1SQ: begin
                run_mul = 1'b1;
                mul_a   = 34'(r_s1);
                mul_b   = 34'(r_s1);
                if (mul_done) begin
                    n_s1sq  = p_rnd30[QW-1:0];
                    n_state = hts_pkg::S_S2SQ;
                end
            end
            hts_pkg::S_S2SQ: begin
                run_mul = 1'b1;
                mul_a   = 34'(r_s2);
                mul_b   = 34'(r_s2);
                if (mul_done) begin
                    n_s2sq  = p_rnd30[QW-1:0];
                    n_state = hts_pkg::S_CC;
                end
            end
            hts_pkg::S_CC: begin
                run_mul = 1'b1;
                mul_a   = 34'(r_c1m);
                mul_b   = 34'(r_c2m);
                if (mul_done) begin
                    n_ccn   = r_c1n ^ r_c2n;
                    n_ccm   = (r_c1n ^ r_c2n) ? p_ceil30[QW-1:0] : p_floor30[QW-1:0];
                    n_state = hts_pkg::S_A;
                end
            end
            hts_pkg::S_A: begin
                run_mul = 1'b1;
                mul_a   = 34'(r_ccm);
                mul_b   = 34'(r_s2sq);
                if (mul_done) begin
                    n_a     = clamp_q30(a_sum);
                    n_state = hts_pkg::S_SQY;
                end
            end
            hts_pkg::S_SQY: begin
                run_sq = 1'b1;
                if (sq_done) begin
                    n_sy    = sq_root;
                    n_state = hts_pkg::S_SQX;
                end
            end
            hts_pkg::S_SQX: begin
                run_sq = 1'b1;
                sq_n   = hts_pkg::SQ_NW'(QW'(hts_pkg::ONE_Q30) - r_a) << 30;
                if (sq_done) begin
                    n_sx    = sq_root;
                    n_state = hts_pkg::S_ATAN;
                end
            end
            hts_pkg::S_ATAN: begin
                run_cor  = 1'b1;
                cor_mode = hts_pkg::CM_VECTOR;
                cor_x0   = CW'(r_sx);
                cor_y0   = CW'(r_sy);
                cor_z0   = '0;
                if (cor_done) begin
                    n_theta = cor_z[CW-1] ? '0 : CW'(cor_z);
                    n_state = hts_pkg::S_MM;
                end
            end
            hts_pkg::S_MM: begin
                run_mul = 1'b1;
                mul_a   = r2000;
                mul_b   = r_theta;
                if (mul_done) begin
                    n_mm    = p_rnd30[34:0];
                    n_state = hts_pkg::S_FIN;
                end
            end
            hts_pkg::S_FIN: begin
                if (sum[DW]) begin
                    n_total = '1;
                    n_ovf   = 1'b1;
                end else begin
                    n_total = sum[DW-1:0];
                end
                n_plat      = r_lat;
                n_plon      = r_lon;
                n_have_prev = 1'b1;
                n_state     = r_last ? hts_pkg::S_OUT : hts_pkg::S_IDLE;
            end
            hts_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_item.total_distance_mm = r_total;
                    n_out_item.saturated         = r_ovf;
                    n_out_valid = 1'b1;
                    n_total     = '0;
                    n_ovf       = 1'b0;
                    n_have_prev = 1'b0;
                    n_plat      = '0;
                    n_plon      = '0;
                    n_state     = hts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hts_pkg::S_IDLE;
            end
        endcase

        mul_start = run_mul && !r_issued;
        cor_start = run_cor && !r_issued;
        sq_start  = run_sq && !r_issued;
        if (run_mul || run_cor || run_sq) begin
            n_issued = !step_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hts_pkg::S_IDLE;
            r_issued    <= 1'b0;
            r_radius    <= hts_pkg::RADIUS_RESET;
            r_have_prev <= 1'b0;
            r_ovf       <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_radius    <= n_radius;
            r_have_prev <= n_have_prev;
            r_ovf       <= n_ovf;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lat      <= n_lat;
        r_lon      <= n_lon;
        r_last     <= n_last;
        r_plat     <= n_plat;
        r_plon     <= n_plon;
        r_ang      <= n_ang;
        r_s1       <= n_s1;
        r_s2       <= n_s2;
        r_c1m      <= n_c1m;
        r_c2m      <= n_c2m;
        r_c1n      <= n_c1n;
        r_c2n      <= n_c2n;
        r_s1sq     <= n_s1sq;
        r_s2sq     <= n_s2sq;
        r_ccm      <= n_ccm;
        r_ccn      <= n_ccn;
        r_a        <= n_a;
        r_sy       <= n_sy;
        r_sx       <= n_sx;
        r_theta    <= n_theta;
        r_mm       <= n_mm;
        r_out_item <= n_out_item;
    end

    hts_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    hts_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_mode  (cor_mode),
        .i_x     (cor_x0),
        .i_y     (cor_y0),
        .i_z     (cor_z0),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_z     (cor_z)
    );

    hts_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (sq_n),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign o_in_ready  = (r_state == hts_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[sv/hts_checker.sv]
// Port-level assertions for the haversine track distance block, bound to the top level.
module hts_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input hts_pkg::t_out_item           o_out_item,
    input logic                         i_cfg_we,
    input logic [hts_pkg::RADIUS_W-1:0] i_cfg_wdata
);
    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed or dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("second item taken while one is in work");

    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.saturated |-> o_out_item.total_distance_mm == '1)
        else $error("saturated total below full scale");

    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result item appeared from idle");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> o_in_ready && !$isunknown(i_cfg_wdata))
        else $error("configuration written while an item is in work");

endmodule

bind haversine_track_distance hts_checker u_hts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata)
);
